// File: src/sst_pkg.sv
// Shared types and constants for the shortest-path block.
package sst_pkg;

	localparam int NODE_W = 7;
	localparam int WEIGHT_W = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam logic signed [WEIGHT_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [WEIGHT_W-1:0] INT_MIN = 32'sh8000_0000;

	// One stored edge
	typedef struct packed {
		logic signed [WEIGHT_W-1:0] edge_weight;
		logic [NODE_W-1:0]          to_node;
		logic [NODE_W-1:0]          from_node;
	} edge_t;

	// One classified input word on its way to the back end
	typedef struct packed {
		edge_t edge_data;
		logic  keep;       // room left in the edge list
		logic  last_edge;  // run the search after this word
	} item_t;

	// One reported node
	typedef struct packed {
		logic [NODE_W-1:0]          node_number;
		logic signed [WEIGHT_W-1:0] path_length;
		logic                       is_reachable;
		logic                       last_node;
	} result_t;

endpackage

// File: src/sst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                     wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: src/sst_front.sv
// Input stage: accept edge words, mark whether each fits in the edge list.
module sst_front
	import sst_pkg::*;
#(
	parameter int MAX_EDGES = 256
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  edge_t in_edge,
	input  logic  in_last,
	output logic  push_valid,
	input  logic  push_ready,
	output item_t push_item
);

	localparam int ECW = $clog2(MAX_EDGES + 1);

	logic [ECW-1:0] fill_q;
	logic           valid_s1;
	item_t          item_s1;
	logic           take;
	logic           keep;

	assign in_ready   = !valid_s1 || push_ready;
	assign take       = in_valid && in_ready;
	assign keep       = (fill_q != ECW'(MAX_EDGES));
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// Track the list fill and hold the classified word until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
				if (in_last) begin
					fill_q <= '0;
				end else if (keep) begin
					fill_q <= fill_q + ECW'(1);
				end
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.edge_data <= in_edge;
			item_s1.keep      <= keep;
			item_s1.last_edge <= in_last;
		end
	end

endmodule

// File: src/sst_queue.sv
// Short queue between the input stage and the search engine.
module sst_queue
	import sst_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: src/sst_back.sv
// Search engine: store edges, run the relaxation passes, report each node.
module sst_back
	import sst_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [NODE_W-1:0] node_count,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  item_t             pop_item,
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res_data
);

	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int EA  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int NW  = $clog2(MAX_NODES + 1);
	localparam int NA  = $clog2(MAX_NODES);
	localparam int CW  = (NW > NODE_W) ? NW : NODE_W;

	typedef enum logic [3:0] {
		S_LOAD, S_INIT, S_ERD, S_DRD, S_ADD, S_UPD, S_ORD, S_OLD, S_OHOLD
	} state_t;

	state_t         state_q;
	logic [ECW-1:0] total_q;
	logic [ECW-1:0] k_q;
	logic [NW-1:0]  n_q;
	logic [NW-1:0]  pass_q;
	logic [NA-1:0]  i_q;
	logic [MAX_NODES-1:0] reached_q;
	logic [NA-1:0]  a_idx_q;
	logic [NA-1:0]  b_idx_q;
	logic           range_ok_q;
	logic signed [WEIGHT_W-1:0] weight_q;
	logic signed [WEIGHT_W-1:0] sum_q;

	// Memory ports
	logic                edge_wr;
	logic [$bits(edge_t)-1:0] edge_rd_raw;
	edge_t               edge_rd;
	logic                dist_wr;
	logic [NA-1:0]       dist_wr_addr;
	logic signed [WEIGHT_W-1:0] dist_wr_data;
	logic [NA-1:0]       dist_a_addr;
	logic [WEIGHT_W-1:0] dist_a_raw;
	logic [WEIGHT_W-1:0] dist_b_raw;
	logic signed [WEIGHT_W-1:0] dist_a;
	logic signed [WEIGHT_W-1:0] dist_b;

	// Derived values
	logic [CW-1:0]  nc_ext;
	logic [NW-1:0]  n_eff;
	logic [CW-1:0]  from_ext;
	logic [CW-1:0]  to_ext;
	logic [CW-1:0]  from_m1;
	logic [CW-1:0]  to_m1;
	logic           from_ok;
	logic           to_ok;
	logic signed [WEIGHT_W:0] sum_wide;
	logic signed [WEIGHT_W-1:0] sum_sat;
	logic           relax;
	logic           last_edge_idx;
	logic           last_pass;
	logic           last_out;

	assign edge_rd = edge_t'(edge_rd_raw);
	assign dist_a  = $signed(dist_a_raw);
	assign dist_b  = $signed(dist_b_raw);

	// Clamp the node count to 1..MAX_NODES
	assign nc_ext = CW'(node_count);
	always_comb begin
		if (nc_ext == '0) begin
			n_eff = NW'(1);
		end else if (nc_ext > CW'(MAX_NODES)) begin
			n_eff = NW'(MAX_NODES);
		end else begin
			n_eff = nc_ext[NW-1:0];
		end
	end

	// Endpoint range check and zero-based node indexes
	assign from_ext = CW'(edge_rd.from_node);
	assign to_ext   = CW'(edge_rd.to_node);
	assign from_m1  = from_ext - CW'(1);
	assign to_m1    = to_ext - CW'(1);
	assign from_ok  = (from_ext != '0) && (from_ext <= CW'(n_q));
	assign to_ok    = (to_ext != '0) && (to_ext <= CW'(n_q));

	// Saturating distance plus weight
	assign sum_wide = {dist_a[WEIGHT_W-1], dist_a} + {weight_q[WEIGHT_W-1], weight_q};
	always_comb begin
		if (sum_wide[WEIGHT_W] != sum_wide[WEIGHT_W-1]) begin
			sum_sat = sum_wide[WEIGHT_W] ? INT_MIN : INT_MAX;
		end else begin
			sum_sat = sum_wide[WEIGHT_W-1:0];
		end
	end

	assign relax = range_ok_q && reached_q[a_idx_q]
		&& (!reached_q[b_idx_q] || (sum_q < dist_b));
	assign last_edge_idx = ((k_q + ECW'(1)) == total_q);
	assign last_pass     = ((pass_q + NW'(1)) == n_q);
	assign last_out      = ((NW'(i_q) + NW'(1)) == n_q);

	// Memory control
	assign pop_ready    = (state_q == S_LOAD);
	assign edge_wr      = pop_valid && pop_ready && pop_item.keep;
	assign dist_wr      = (state_q == S_INIT) || ((state_q == S_UPD) && relax);
	assign dist_wr_addr = (state_q == S_INIT) ? NA'(0) : b_idx_q;
	assign dist_wr_data = (state_q == S_INIT) ? '0 : sum_q;
	assign dist_a_addr  = (state_q == S_DRD) ? from_m1[NA-1:0] : i_q;

	sst_ram #(
		.WIDTH($bits(edge_t)),
		.DEPTH(MAX_EDGES)
	) u_edge_ram (
		.clk    (clk),
		.wr_en  (edge_wr),
		.wr_addr(total_q[EA-1:0]),
		.wr_data(pop_item.edge_data),
		.rd_addr(k_q[EA-1:0]),
		.rd_data(edge_rd_raw)
	);

	// Two copies of the distances give a read at each end of an edge
	sst_ram #(
		.WIDTH(WEIGHT_W),
		.DEPTH(MAX_NODES)
	) u_dist_a_ram (
		.clk    (clk),
		.wr_en  (dist_wr),
		.wr_addr(dist_wr_addr),
		.wr_data(dist_wr_data),
		.rd_addr(dist_a_addr),
		.rd_data(dist_a_raw)
	);

	sst_ram #(
		.WIDTH(WEIGHT_W),
		.DEPTH(MAX_NODES)
	) u_dist_b_ram (
		.clk    (clk),
		.wr_en  (dist_wr),
		.wr_addr(dist_wr_addr),
		.wr_data(dist_wr_data),
		.rd_addr(to_m1[NA-1:0]),
		.rd_data(dist_b_raw)
	);

	// Sequencer: load, initialise, relax edge by edge, then report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			total_q    <= '0;
			k_q        <= '0;
			n_q        <= NW'(1);
			pass_q     <= NW'(1);
			i_q        <= '0;
			reached_q  <= '0;
			range_ok_q <= 1'b0;
			res_valid  <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (pop_valid) begin
						if (pop_item.keep) begin
							total_q <= total_q + ECW'(1);
						end
						if (pop_item.last_edge) begin
							n_q     <= n_eff;
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					// Only node 1 starts out reached
					reached_q    <= MAX_NODES'(1);
					pass_q       <= NW'(1);
					k_q          <= '0;
					i_q          <= '0;
					state_q      <= (n_q == NW'(1)) ? S_ORD : S_ERD;
				end
				S_ERD: begin
					state_q <= S_DRD;
				end
				S_DRD: begin
					range_ok_q <= from_ok && to_ok;
					state_q    <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (relax) begin
						reached_q[b_idx_q] <= 1'b1;
					end
					if (last_edge_idx) begin
						k_q <= '0;
						if (last_pass) begin
							state_q <= S_ORD;
						end else begin
							pass_q  <= pass_q + NW'(1);
							state_q <= S_ERD;
						end
					end else begin
						k_q     <= k_q + ECW'(1);
						state_q <= S_ERD;
					end
				end
				S_ORD: begin
					state_q <= S_OLD;
				end
				S_OLD: begin
					res_valid <= 1'b1;
					state_q   <= S_OHOLD;
				end
				S_OHOLD: begin
					if (res_ready) begin
						res_valid <= 1'b0;
						if (res_data.last_node) begin
							total_q <= '0;
							state_q <= S_LOAD;
						end else begin
							i_q     <= i_q + NA'(1);
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Edge and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_DRD) begin
			a_idx_q  <= from_m1[NA-1:0];
			b_idx_q  <= to_m1[NA-1:0];
			weight_q <= edge_rd.edge_weight;
		end
		if (state_q == S_ADD) begin
			sum_q <= sum_sat;
		end
		if (state_q == S_OLD) begin
			res_data.node_number  <= NODE_W'(NW'(i_q) + NW'(1));
			res_data.path_length  <= reached_q[i_q] ? dist_a : INT_MAX;
			res_data.is_reachable <= reached_q[i_q];
			res_data.last_node    <= last_out;
		end
	end

endmodule

// File: src/single_source_shortest_path.sv
// Top level of the single-source shortest-path engine.
//
// Edges stream in one word per cycle while tready is high and are kept in load order
// in an edge RAM of MAX_EDGES entries; words past that limit are dropped, but a last
// mark on them still starts the search. On the last word the engine runs Bellman-Ford
// from node 1 over node_count nodes (0 counts as 1, above MAX_NODES counts as
// MAX_NODES): node_count-1 passes, each relaxing every stored edge through the read
// of the edge RAM, the read of both distance copies, the saturating add and the
// compare and write, in that order. After the search one result per node leaves in
// node order, each held until the output side takes it. Edges from unreached nodes
// are skipped and sums saturate to the 32-bit signed range. During a search the input
// keeps taking words until the front register and the four-word queue are full, then
// holds tready low until the report is finished.
module single_source_shortest_path
	import sst_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,     // node_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // from_node, to_node, edge_weight, zero fill
	input  logic        s_axis_tlast,  // last_edge
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // node_number, path_length, zero fill
	output logic        m_axis_tuser,  // is_reachable
	output logic        m_axis_tlast   // last_node
);

	logic [NODE_W-1:0] node_count_q;
	edge_t             in_edge;
	logic              push_valid;
	logic              push_ready;
	item_t             push_item;
	logic              pop_valid;
	logic              pop_ready;
	item_t             pop_item;
	result_t           res_data;

	// Hold the node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_W'(1);
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Unpack the input word
	assign in_edge.from_node   = s_axis_tdata[6:0];
	assign in_edge.to_node     = s_axis_tdata[13:7];
	assign in_edge.edge_weight = s_axis_tdata[45:14];

	sst_front #(
		.MAX_EDGES(MAX_EDGES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_edge   (in_edge),
		.in_last   (s_axis_tlast),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	sst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	sst_back #(
		.MAX_NODES(MAX_NODES),
		.MAX_EDGES(MAX_EDGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.node_count(node_count_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_data  (res_data)
	);

	// Pack the result word
	assign m_axis_tdata = {1'b0, res_data.path_length, res_data.node_number};
	assign m_axis_tuser = res_data.is_reachable;
	assign m_axis_tlast = res_data.last_node;

endmodule
